@@ rtl/tcw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// Used by the front end, the command queue, the back end and the top level.
package tcw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int KIND_W       = 2;
    localparam int CHAR_W       = 8;
    localparam int INDEX_W      = 11;
    localparam int CELL_W       = 16;
    localparam int COLOR_W      = 4;
    localparam int OUT_COLUMN_W = 7;
    localparam int OUT_ROW_W    = 5;
    localparam int OUT_ADDR_W   = 11;
    localparam int S_DATA_W     = 24;
    localparam int M_DATA_W     = 40;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FORE_COLOR = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_COLOR = 1'd1;

    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [COLOR_W-1:0] FORE_RESET   = 4'h0d;
    localparam logic [COLOR_W-1:0] BACK_RESET   = 4'h0F;
    localparam logic [CELL_W-1:0]  BLANK_CELL   = 16'hFD20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = 1;
    localparam int QUEUE_CW    = 2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_READ,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
        logic               in_range;
    } item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

@@ rtl/tcw_front.sv @@
`timescale 1ns / 1ps
// Front end: takes input words, decodes them into queue commands.
// Depends on tcw_pkg.
module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
)
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [KIND_W-1:0]   s_tuser,
    input  logic                accept_en,
    input  logic                full,
    output logic                push,
    output item_t               push_item
);

    localparam int CELLS = COLUMNS * ROWS;

    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;

    assign char_code  = s_tdata[CHAR_W-1:0];
    assign cell_index = s_tdata[CHAR_W+INDEX_W-1:CHAR_W];
    assign s_tready   = accept_en && !full;
    assign push       = s_tvalid && s_tready;

    always_comb
    begin
        push_item.char_code  = char_code;
        push_item.cell_index = cell_index;
        push_item.in_range   = (32'(cell_index) < CELLS);
        case (s_tuser)
            KIND_PUT:
            begin
                if (char_code == NEWLINE_CHAR)
                begin
                    push_item.op = OP_NEWLINE;
                end
                else
                begin
                    push_item.op = OP_PUT;
                end
            end
            KIND_READ:  push_item.op = OP_READ;
            KIND_CLEAR: push_item.op = OP_CLEAR;
            default:    push_item.op = OP_NOP;
        endcase
    end

endmodule

@@ rtl/tcw_queue.sv @@
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the back end.
// Depends on tcw_pkg.
module tcw_queue
    import tcw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t pop_item,
    output logic  empty
);

    item_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PW-1:0] wr_ptr_reg;
    logic [QUEUE_PW-1:0] wr_ptr_next;
    logic [QUEUE_PW-1:0] rd_ptr_reg;
    logic [QUEUE_PW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QUEUE_PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QUEUE_PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QUEUE_CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = QUEUE_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("push into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty) else $error("pop from an empty queue");

endmodule

@@ rtl/tcw_back.sv @@
`timescale 1ns / 1ps
// Back end: screen store, cursor, scroll and clear sweeps, result register.
// Depends on tcw_pkg; fed by tcw_queue.
module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data,
    input  logic                   empty,
    input  item_t                  pop_item,
    output logic                   pop,
    output logic                   init_done,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_W-1:0]    m_tdata
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int MOVE_LAST = CELLS - COLUMNS;
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    logic [CELL_W-1:0]   mem [CELLS];
    logic [CELL_W-1:0]   rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    state_t              state_reg;
    state_t              state_next;
    logic [AW-1:0]       sweep_reg;
    logic [AW-1:0]       sweep_next;
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [RW-1:0]       row_reg;
    logic [RW-1:0]       row_next;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       addr_next;
    logic                scrolled_reg;
    logic                scrolled_next;
    logic                read_ok_reg;
    logic                read_ok_next;
    logic [CELL_W-1:0]   word_reg;
    logic [CELL_W-1:0]   word_next;
    logic [COLOR_W-1:0]  fore_reg;
    logic [COLOR_W-1:0]  back_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic                load_out;
    logic                row_step;

    assign init_done = (state_reg != ST_INIT);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign row_step  = (pop_item.op == OP_NEWLINE) || (col_reg == CW'(COLUMNS - 1));

    always_comb
    begin
        state_next    = state_reg;
        sweep_next    = sweep_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        addr_next     = addr_reg;
        scrolled_next = scrolled_reg;
        read_ok_next  = read_ok_reg;
        word_next     = word_reg;
        mem_we        = 1'b0;
        mem_waddr     = sweep_reg;
        mem_wdata     = BLANK_CELL;
        mem_re        = 1'b0;
        mem_raddr     = AW'(32'(sweep_reg) + COLUMNS);
        pop           = 1'b0;
        load_out      = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = AW'(sweep_reg + 1'b1);
                end
            end
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop           = 1'b1;
                    scrolled_next = 1'b0;
                    word_next     = '0;
                    state_next    = ST_DONE;
                    case (pop_item.op)
                        OP_PUT, OP_NEWLINE:
                        begin
                            if (pop_item.op == OP_PUT)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_reg;
                                mem_wdata = {back_reg, fore_reg, pop_item.char_code};
                            end
                            if (!row_step)
                            begin
                                col_next  = CW'(col_reg + 1'b1);
                                addr_next = AW'(addr_reg + 1'b1);
                            end
                            else if (row_reg == RW'(ROWS - 1))
                            begin
                                col_next      = '0;
                                addr_next     = AW'(LAST_BASE);
                                scrolled_next = 1'b1;
                                sweep_next    = '0;
                                state_next    = ST_SCROLL;
                            end
                            else
                            begin
                                col_next  = '0;
                                row_next  = RW'(row_reg + 1'b1);
                                addr_next = AW'(32'(addr_reg) - 32'(col_reg) + COLUMNS);
                            end
                        end
                        OP_READ:
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = AW'(pop_item.cell_index);
                            read_ok_next = pop_item.in_range;
                            state_next   = ST_READ;
                        end
                        OP_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            addr_next  = '0;
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                word_next  = read_ok_reg ? rdata_reg : '0;
                state_next = ST_DONE;
            end
            ST_SCROLL:
            begin
                // Reads run one cell ahead of the writes one row up.
                if (sweep_reg != AW'(MOVE_LAST))
                begin
                    mem_re = 1'b1;
                end
                if (sweep_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(sweep_reg - 1'b1);
                    mem_wdata = rdata_reg;
                end
                if (sweep_reg == AW'(MOVE_LAST))
                begin
                    state_next = ST_BLANK;
                end
                else
                begin
                    sweep_next = AW'(sweep_reg + 1'b1);
                end
            end
            ST_BLANK, ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    sweep_next = AW'(sweep_reg + 1'b1);
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            addr_reg      <= '0;
            scrolled_reg  <= 1'b0;
            read_ok_reg   <= 1'b0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            addr_reg      <= addr_next;
            scrolled_reg  <= scrolled_next;
            read_ok_reg   <= read_ok_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg <= FORE_RESET;
            back_reg <= BACK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FORE_COLOR: fore_reg <= cfg_data;
                CFG_BACK_COLOR: back_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= {scrolled_reg, OUT_ADDR_W'(addr_reg), OUT_ROW_W'(row_reg),
                             OUT_COLUMN_W'(col_reg), word_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE) else $error("command taken outside idle");

    a_cursor_addr: assert property (@(posedge clk) disable iff (!rst_n)
        32'(addr_reg) == 32'(row_reg) * COLUMNS + 32'(col_reg))
        else $error("cursor address out of step with row and column");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < COLUMNS && 32'(row_reg) < ROWS)
        else $error("cursor outside the screen");

    a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCROLL) |-> (row_reg == RW'(ROWS - 1)) && scrolled_reg)
        else $error("scroll without cursor on the last row");

endmodule

@@ rtl/text_console_writer_core.sv @@
`timescale 1ns / 1ps
// Top level of the text console writer: front end, command queue, back end.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
//  Channel   Direction  Signals                     Contents
//  s_*       in         s_tvalid s_tready s_tdata   console commands
//  m_*       out        m_tvalid m_tready m_tdata   one result word per command
//  cfg_*     in         cfg_we cfg_index cfg_data   color registers
//
// A put or newline passes the idle and done states of the back-end sequencer; a
// read also passes the read state, set by the registered read port of the store.
// A clear blanks every cell in one sweep; a scroll moves each row up one and then
// blanks the last row. The sweeps make at most one store write per cycle.
// After reset the store is swept to zero, all COLUMNS*ROWS cells (2000 by
// default) with s_tready low. A stalled m_* side holds one result in the output
// register and one more in the back end, and the queue takes up to two more
// commands before s_tready drops.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEFAULT,
    parameter int ROWS    = ROWS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,   // char_code[7:0], cell_index[18:8], zero
    input  logic [KIND_W-1:0]      s_tuser,   // kind[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // cell_word[15:0], cursor_column[22:16], cursor_row[27:23],
    // cursor_addr[38:28], scrolled[39]
    output logic [M_DATA_W-1:0]    m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]     cfg_data
);

    logic  push;
    item_t push_item;
    logic  full;
    logic  pop;
    item_t pop_item;
    logic  empty;
    logic  init_done;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .accept_en (init_done),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop_item  (pop_item),
        .pop       (pop),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
